>>> hdl/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

    // default geometry of one coordinate
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // digit width of the partial products inside the multipliers
    localparam int MUL_DIGIT = 32;

    // tolerance registers
    localparam int TOL_BITS = 16;
    localparam int CFG_DW   = 32;
    localparam int CFG_AW   = 3;
    localparam logic REG_ZERO_TOL  = 1'b0;
    localparam logic REG_EQUAL_TOL = 1'b1;

    // depth of the queue between front and back, power of two
    localparam int FIFO_DEPTH = 4;

    // what the back end does with one coordinate
    typedef enum logic [2:0] {
        K_ZERO,
        K_ONE,
        K_DIV,
        K_SAT_POS,
        K_SAT_NEG
    } t_kind;

    // per-item control travelling from front to back
    typedef struct packed {
        t_kind kind_x;
        t_kind kind_y;
        logic  neg_x;
        logic  neg_y;
        logic  collinear;
    } t_ctl;

endpackage
`default_nettype wire

>>> hdl/tcc_mul.sv
`default_nettype none
// Signed multiplier: registered digit partial products, then their registered sum.
module tcc_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire  signed [AW-1:0]      i_a,
    input  wire  signed [BW-1:0]      i_b,
    output logic signed [AW+BW-1:0]   o_p
);
    import tcc_pkg::*;

    localparam int DW = MUL_DIGIT;
    localparam int NA = (AW + DW - 1) / DW;
    localparam int NB = (BW + DW - 1) / DW;
    localparam int EA = NA * DW;
    localparam int EB = NB * DW;
    localparam int PW = AW + BW;

    logic signed [EA-1:0]     w_a;
    logic signed [EB-1:0]     w_b;
    logic signed [DW:0]       w_da [NA];
    logic signed [DW:0]       w_db [NB];
    logic signed [2*DW+1:0]   r_pp [NA][NB];
    logic signed [PW-1:0]     w_sum;

    assign w_a = EA'(i_a);
    assign w_b = EB'(i_b);

    // split into digits: lower digits unsigned, top digit carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                w_da[i] = {w_a[EA-1], w_a[i*DW +: DW]};
            end else begin
                w_da[i] = {1'b0, w_a[i*DW +: DW]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                w_db[j] = {w_b[EB-1], w_b[j*DW +: DW]};
            end else begin
                w_db[j] = {1'b0, w_b[j*DW +: DW]};
            end
        end
    end

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= w_da[i] * w_db[j];
                end
            end
        end
    end

    // weighted sum, modulo 2^PW where the true product always fits
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_sum = w_sum + (PW'(r_pp[i][j]) <<< (DW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= w_sum;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tcc_front.sv
`default_nettype none
// Front end: determinants, tolerance tests and sorting of each coordinate.
module tcc_front #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [COORD_BITS-1:0]          i_xa,
    input  wire  signed [COORD_BITS-1:0]          i_ya,
    input  wire  signed [COORD_BITS-1:0]          i_xb,
    input  wire  signed [COORD_BITS-1:0]          i_yb,
    input  wire  signed [COORD_BITS-1:0]          i_xc,
    input  wire  signed [COORD_BITS-1:0]          i_yc,
    input  wire         [tcc_pkg::TOL_BITS-1:0]   i_zero_tol,
    input  wire         [tcc_pkg::TOL_BITS-1:0]   i_equal_tol,
    input  wire                                   i_full,
    output logic                                  o_push,
    output tcc_pkg::t_ctl                         o_ctl,
    output logic        [3*COORD_BITS+5:0]        o_nax,
    output logic        [3*COORD_BITS+5:0]        o_nay,
    output logic        [2*COORD_BITS+4:0]        o_da
);
    import tcc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int D     = C + 1;
    localparam int P_W   = 2 * D;
    localparam int DEN_W = 2 * D + 3;
    localparam int DN_W  = 2 * D + 1;
    localparam int M_W   = DN_W + D;
    localparam int NW    = M_W + 2;
    localparam int DS_W  = DEN_W + C;
    localparam int EW    = ((NW > DEN_W + F) ? NW : DEN_W + F) + 1;
    localparam int TW    = TOL_BITS + 2;
    localparam int LAST  = 8;
    localparam logic ONE_SAT = (F >= C - 1);

    logic en;
    logic r_v [LAST+1];

    // stage 0: input
    logic signed [C-1:0] r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    // stage 1: differences and sums
    logic signed [D-1:0] r_dxb1, r_dyb1, r_dxc1, r_dyc1;
    logic signed [D-1:0] r_sxb1, r_syb1, r_sxc1, r_syc1;
    // stages 2 and 3: differences carried past the first multipliers
    logic signed [D-1:0] r_dxb2, r_dyb2, r_dxc2, r_dyc2;
    logic signed [D-1:0] r_dxb3, r_dyb3, r_dxc3, r_dyc3;
    logic signed [P_W-1:0] w_p1, w_p2, w_q1, w_q2, w_q3, w_q4;
    // stage 4: denominator and norm differences
    logic signed [DEN_W-1:0] r_den4, r_den5, r_den6;
    logic signed [DN_W-1:0]  r_dnb4, r_dnc4;
    logic signed [D-1:0]     r_dxb4, r_dyb4, r_dxc4, r_dyc4;
    logic signed [M_W-1:0]   w_m1, w_m2, w_m3, w_m4;
    // stage 7: numerators
    logic signed [NW-1:0]    r_nx7, r_ny7;
    logic signed [DEN_W-1:0] r_den7;
    logic signed [DS_W-1:0]  r_ds7;
    // stage 8: magnitudes and tests
    logic        [NW-1:0]    r_nax, r_nay;
    logic        [DEN_W-1:0] r_da;
    logic        [DS_W-1:0]  r_dsa;
    logic signed [EW-1:0]    r_dfx, r_dfy;
    logic                    r_sgx, r_sgy, r_dz, r_nzx, r_nzy;

    logic signed [TW-1:0] w_zt, w_nzt, w_et, w_net;
    logic                 w_dz, w_nzx, w_nzy;
    logic                 w_eqx, w_eqy, w_origin;
    logic        [NW-1:0] w_lim_pos, w_lim_neg;

    // whole pipeline moves unless its last item cannot enter the queue
    assign en      = !(r_v[LAST] && i_full);
    assign o_ready = en;
    assign o_push  = r_v[LAST] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // first multiplier bank: cross products and norm differences
    tcc_mul #(.AW(D), .BW(D)) u_mul_p1 (.i_clk, .i_en(en), .i_a(r_dxb1), .i_b(r_dyc1), .o_p(w_p1));
    tcc_mul #(.AW(D), .BW(D)) u_mul_p2 (.i_clk, .i_en(en), .i_a(r_dxc1), .i_b(r_dyb1), .o_p(w_p2));
    tcc_mul #(.AW(D), .BW(D)) u_mul_q1 (.i_clk, .i_en(en), .i_a(r_dxb1), .i_b(r_sxb1), .o_p(w_q1));
    tcc_mul #(.AW(D), .BW(D)) u_mul_q2 (.i_clk, .i_en(en), .i_a(r_dyb1), .i_b(r_syb1), .o_p(w_q2));
    tcc_mul #(.AW(D), .BW(D)) u_mul_q3 (.i_clk, .i_en(en), .i_a(r_dxc1), .i_b(r_sxc1), .o_p(w_q3));
    tcc_mul #(.AW(D), .BW(D)) u_mul_q4 (.i_clk, .i_en(en), .i_a(r_dyc1), .i_b(r_syc1), .o_p(w_q4));

    // second multiplier bank: numerator terms
    tcc_mul #(.AW(DN_W), .BW(D)) u_mul_m1 (.i_clk, .i_en(en), .i_a(r_dnb4), .i_b(r_dyc4), .o_p(w_m1));
    tcc_mul #(.AW(DN_W), .BW(D)) u_mul_m2 (.i_clk, .i_en(en), .i_a(r_dnc4), .i_b(r_dyb4), .o_p(w_m2));
    tcc_mul #(.AW(DN_W), .BW(D)) u_mul_m3 (.i_clk, .i_en(en), .i_a(r_dnc4), .i_b(r_dxb4), .o_p(w_m3));
    tcc_mul #(.AW(DN_W), .BW(D)) u_mul_m4 (.i_clk, .i_en(en), .i_a(r_dnb4), .i_b(r_dxc4), .o_p(w_m4));

    // tolerance windows
    assign w_zt  = TW'($signed({1'b0, i_zero_tol}));
    assign w_nzt = -w_zt;
    assign w_et  = TW'($signed({1'b0, i_equal_tol}));
    assign w_net = -w_et;

    assign w_dz  = (r_den7 <= w_zt) && (r_den7 >= w_nzt);
    assign w_nzx = (r_nx7 <= w_zt) && (r_nx7 >= w_nzt);
    assign w_nzy = (r_ny7 <= w_zt) && (r_ny7 >= w_nzt);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xa <= i_xa;
            r_ya <= i_ya;
            r_xb <= i_xb;
            r_yb <= i_yb;
            r_xc <= i_xc;
            r_yc <= i_yc;

            r_dxb1 <= D'(r_xb) - D'(r_xa);
            r_dyb1 <= D'(r_yb) - D'(r_ya);
            r_dxc1 <= D'(r_xc) - D'(r_xa);
            r_dyc1 <= D'(r_yc) - D'(r_ya);
            r_sxb1 <= D'(r_xb) + D'(r_xa);
            r_syb1 <= D'(r_yb) + D'(r_ya);
            r_sxc1 <= D'(r_xc) + D'(r_xa);
            r_syc1 <= D'(r_yc) + D'(r_ya);

            r_dxb2 <= r_dxb1;
            r_dyb2 <= r_dyb1;
            r_dxc2 <= r_dxc1;
            r_dyc2 <= r_dyc1;
            r_dxb3 <= r_dxb2;
            r_dyb3 <= r_dyb2;
            r_dxc3 <= r_dxc2;
            r_dyc3 <= r_dyc2;

            r_den4 <= (DEN_W'(w_p1) - DEN_W'(w_p2)) <<< 2;
            r_dnb4 <= DN_W'(w_q1) + DN_W'(w_q2);
            r_dnc4 <= DN_W'(w_q3) + DN_W'(w_q4);
            r_dxb4 <= r_dxb3;
            r_dyb4 <= r_dyb3;
            r_dxc4 <= r_dxc3;
            r_dyc4 <= r_dyc3;

            r_den5 <= r_den4;
            r_den6 <= r_den5;

            r_nx7  <= (NW'(w_m1) - NW'(w_m2)) <<< 1;
            r_ny7  <= (NW'(w_m3) - NW'(w_m4)) <<< 1;
            r_den7 <= r_den6;
            r_ds7  <= DS_W'(r_den6) + (DS_W'(r_den6) <<< (C - 1));

            r_nax <= r_nx7[NW-1] ? $unsigned(-r_nx7) : $unsigned(r_nx7);
            r_nay <= r_ny7[NW-1] ? $unsigned(-r_ny7) : $unsigned(r_ny7);
            r_da  <= r_den7[DEN_W-1] ? $unsigned(-r_den7) : $unsigned(r_den7);
            r_dsa <= r_ds7[DS_W-1] ? $unsigned(-r_ds7) : $unsigned(r_ds7);
            r_dfx <= EW'(r_nx7) - (EW'(r_den7) <<< F);
            r_dfy <= EW'(r_ny7) - (EW'(r_den7) <<< F);
            r_sgx <= r_nx7[NW-1] ^ r_den7[DEN_W-1];
            r_sgy <= r_ny7[NW-1] ^ r_den7[DEN_W-1];
            r_dz  <= w_dz;
            r_nzx <= w_nzx;
            r_nzy <= w_nzy;
        end
    end

    // sorting of each coordinate
    assign w_eqx     = (r_dfx <= w_et) && (r_dfx >= w_net);
    assign w_eqy     = (r_dfy <= w_et) && (r_dfy >= w_net);
    assign w_origin  = r_dz || (r_nzx && r_nzy);
    assign w_lim_pos = NW'(r_da) << (C - 1);
    assign w_lim_neg = NW'(r_dsa);

    function automatic t_kind pick(input logic nz, input logic eq, input logic neg,
                                   input logic [NW-1:0] mag, input logic [NW-1:0] lp,
                                   input logic [NW-1:0] ln);
        t_kind k;
        if (nz) begin
            k = K_ZERO;
        end else if (eq) begin
            k = ONE_SAT ? K_SAT_POS : K_ONE;
        end else if (neg) begin
            k = (mag >= ln) ? K_SAT_NEG : K_DIV;
        end else begin
            k = (mag >= lp) ? K_SAT_POS : K_DIV;
        end
        return k;
    endfunction

    always_comb begin
        o_ctl.collinear = r_dz;
        o_ctl.neg_x     = r_sgx;
        o_ctl.neg_y     = r_sgy;
        if (w_origin) begin
            o_ctl.kind_x = K_ZERO;
            o_ctl.kind_y = K_ZERO;
        end else begin
            o_ctl.kind_x = pick(r_nzx, w_eqx, r_sgx, r_nax, w_lim_pos, w_lim_neg);
            o_ctl.kind_y = pick(r_nzy, w_eqy, r_sgy, r_nay, w_lim_pos, w_lim_neg);
        end
    end

    assign o_nax = r_nax;
    assign o_nay = r_nay;
    assign o_da  = r_da;

endmodule
`default_nettype wire

>>> hdl/tcc_fifo.sv
`default_nettype none
// Short register queue between front and back.
module tcc_fifo #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_wdata,
    input  wire          i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    import tcc_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]  r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/tcc_back.sv
`default_nettype none
// Back end: two restoring dividers, one quotient bit per stage, and the result register.
module tcc_back #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_empty,
    output logic                          o_pop,
    input  wire  tcc_pkg::t_ctl           i_ctl,
    input  wire  [3*COORD_BITS+5:0]       i_nax,
    input  wire  [3*COORD_BITS+5:0]       i_nay,
    input  wire  [2*COORD_BITS+4:0]       i_da,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic signed [COORD_BITS-1:0]  o_cx,
    output logic signed [COORD_BITS-1:0]  o_cy,
    output logic                          o_collinear,
    output logic                          o_saturated
);
    import tcc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int NW    = 3 * C + 6;
    localparam int DEN_W = 2 * C + 5;

    logic             en;
    logic             r_v   [C+1];
    t_ctl             r_ctl [C+1];
    logic [NW-1:0]    r_rx  [C+1];
    logic [NW-1:0]    r_ry  [C+1];
    logic [DEN_W-1:0] r_d   [C+1];
    logic [C-1:0]     r_qx  [C+1];
    logic [C-1:0]     r_qy  [C+1];

    logic [NW-1:0]    w_sh  [1:C];
    logic [NW-1:0]    w_rx  [1:C];
    logic [NW-1:0]    w_ry  [1:C];
    logic [C-1:0]     w_qx  [1:C];
    logic [C-1:0]     w_qy  [1:C];

    logic             r_ov;
    logic [C-1:0]     r_cx, r_cy;
    logic             r_col, r_sat;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= C; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
            for (int k = 1; k <= C; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[C];
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int k = 1; k <= C; k++) begin
            w_sh[k] = NW'(r_d[k-1]) << (C - k);
            w_rx[k] = r_rx[k-1];
            w_ry[k] = r_ry[k-1];
            w_qx[k] = r_qx[k-1];
            w_qy[k] = r_qy[k-1];
            if (r_rx[k-1] >= w_sh[k]) begin
                w_rx[k]      = r_rx[k-1] - w_sh[k];
                w_qx[k][C-k] = 1'b1;
            end
            if (r_ry[k-1] >= w_sh[k]) begin
                w_ry[k]      = r_ry[k-1] - w_sh[k];
                w_qy[k][C-k] = 1'b1;
            end
        end
    end

    function automatic logic [C-1:0] coord(input t_kind k, input logic neg,
                                           input logic [C-1:0] q);
        logic [C-1:0] v;
        case (k)
            K_ZERO:    v = '0;
            K_ONE:     v = C'(1) << FRAC_BITS;
            K_DIV:     v = neg ? -q : q;
            K_SAT_POS: v = {1'b0, {(C-1){1'b1}}};
            K_SAT_NEG: v = {1'b1, {(C-1){1'b0}}};
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0] <= i_ctl;
            r_rx[0]  <= i_nax;
            r_ry[0]  <= i_nay;
            r_d[0]   <= i_da;
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            for (int k = 1; k <= C; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_d[k]   <= r_d[k-1];
                r_rx[k]  <= w_rx[k];
                r_ry[k]  <= w_ry[k];
                r_qx[k]  <= w_qx[k];
                r_qy[k]  <= w_qy[k];
            end
            // result register
            r_cx  <= coord(r_ctl[C].kind_x, r_ctl[C].neg_x, r_qx[C]);
            r_cy  <= coord(r_ctl[C].kind_y, r_ctl[C].neg_y, r_qy[C]);
            r_col <= r_ctl[C].collinear;
            r_sat <= (r_ctl[C].kind_x == K_SAT_POS) || (r_ctl[C].kind_x == K_SAT_NEG) ||
                     (r_ctl[C].kind_y == K_SAT_POS) || (r_ctl[C].kind_y == K_SAT_NEG);
        end
    end

    assign o_valid     = r_ov;
    assign o_cx        = r_cx;
    assign o_cy        = r_cy;
    assign o_collinear = r_col;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

>>> hdl/triangle_circumcenter_2d.sv
`default_nettype none
// Circumcentre of one 2D triangle per transaction, vertices and result in signed fixed point
// (COORD_BITS wide, FRAC_BITS fraction bits). A new triangle is taken every clock cycle
// unless a full queue stalls the front end; the back end's length is set by the restoring
// dividers that resolve one quotient bit per stage. Multiplications are split into
// registered 32-bit digit products and a registered sum. Quotients truncate towards zero
// and clip to range with the saturated flag; collinear vertices return the origin with the
// collinear flag. Tolerances are written over the APB port at address 0 (zero tolerance)
// and 4 (equal tolerance) by the user only when no triangle is in flight (not enforced).
module triangle_circumcenter_2d #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       s_axis_tvalid,
    output logic                                      s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
    input  wire  [((6*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire                                       m_axis_tready,
    // center_x, center_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
    // collinear, saturated
    output logic [1:0]                                m_axis_tuser,
    input  wire                                       psel,
    input  wire                                       penable,
    input  wire                                       pwrite,
    input  wire  [tcc_pkg::CFG_AW-1:0]                paddr,
    input  wire  [tcc_pkg::CFG_DW-1:0]                pwdata,
    output logic [tcc_pkg::CFG_DW-1:0]                prdata,
    output logic                                      pready
);
    import tcc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int NW    = 3 * C + 6;
    localparam int DEN_W = 2 * C + 5;
    localparam int OUT_W = ((2 * C + 7) / 8) * 8;
    localparam int QW    = $bits(t_ctl) + 2 * NW + DEN_W;

    logic [TOL_BITS-1:0] r_zero_tol, r_equal_tol;
    logic                w_push, w_pop, w_full, w_empty;
    t_ctl                w_ctl_f, w_ctl_b;
    logic [NW-1:0]       w_nax_f, w_nay_f, w_nax_b, w_nay_b;
    logic [DEN_W-1:0]    w_da_f, w_da_b;
    logic [QW-1:0]       w_qin, w_qout;
    logic signed [C-1:0] w_cx, w_cy;
    logic                w_col, w_sat;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol  <= '0;
            r_equal_tol <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_ZERO_TOL:  r_zero_tol  <= pwdata[TOL_BITS-1:0];
                REG_EQUAL_TOL: r_equal_tol <= pwdata[TOL_BITS-1:0];
                default:       r_zero_tol  <= r_zero_tol;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ZERO_TOL:  prdata = CFG_DW'(r_zero_tol);
            REG_EQUAL_TOL: prdata = CFG_DW'(r_equal_tol);
            default:       prdata = '0;
        endcase
    end

    tcc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk,
        .i_rst_n,
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_xa        (s_axis_tdata[0*C +: C]),
        .i_ya        (s_axis_tdata[1*C +: C]),
        .i_xb        (s_axis_tdata[2*C +: C]),
        .i_yb        (s_axis_tdata[3*C +: C]),
        .i_xc        (s_axis_tdata[4*C +: C]),
        .i_yc        (s_axis_tdata[5*C +: C]),
        .i_zero_tol  (r_zero_tol),
        .i_equal_tol (r_equal_tol),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_ctl       (w_ctl_f),
        .o_nax       (w_nax_f),
        .o_nay       (w_nay_f),
        .o_da        (w_da_f)
    );

    assign w_qin = {w_ctl_f, w_nax_f, w_nay_f, w_da_f};
    assign {w_ctl_b, w_nax_b, w_nay_b, w_da_b} = w_qout;

    tcc_fifo #(.W(QW)) u_fifo (
        .i_clk,
        .i_rst_n,
        .i_push  (w_push),
        .i_wdata (w_qin),
        .i_pop   (w_pop),
        .o_rdata (w_qout),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tcc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk,
        .i_rst_n,
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_ctl       (w_ctl_b),
        .i_nax       (w_nax_b),
        .i_nay       (w_nay_b),
        .i_da        (w_da_b),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cx        (w_cx),
        .o_cy        (w_cy),
        .o_collinear (w_col),
        .o_saturated (w_sat)
    );

    assign m_axis_tdata = OUT_W'({w_cy, w_cx});
    assign m_axis_tuser = {w_sat, w_col};

endmodule
`default_nettype wire
